// ===== design/coeoc_pkg.sv =====
// ----------------------------------------------------------------------------
// coeoc_pkg
// Shared types and codes for the cross-owner extent overlap checker: the
// stored extent record, the bus widths and the result status codes.
// ----------------------------------------------------------------------------
package coeoc_pkg;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned LEN_W   = 64;
  localparam int unsigned FRAG_W  = 32;
  localparam int unsigned OWNER_W = 64;
  localparam int unsigned HITS_W  = 32;
  localparam int unsigned STAT_W  = 2;

  // one extent record, start in the lowest bits
  typedef struct packed {
    logic [OWNER_W-1:0]       owner_low;
    logic [OWNER_W-1:0]       owner_high;
    logic signed [FRAG_W-1:0] fragment;
    logic [LEN_W-1:0]         length;
    logic [ADDR_W-1:0]        start;
  } entry_t;

  localparam int unsigned IN_DATA_W  = $bits(entry_t);
  localparam int unsigned OUT_DATA_W = $bits(entry_t) + HITS_W;

  typedef logic [STAT_W-1:0] status_t;

  // result status codes
  localparam status_t STATUS_PAIR = 2'd0;
  localparam status_t STATUS_DONE = 2'd1;
  localparam status_t STATUS_FULL = 2'd2;
  localparam status_t STATUS_ZERO = 2'd3;

endpackage

// ===== design/cross_owner_extent_overlap_check.sv =====
// ----------------------------------------------------------------------------
// cross_owner_extent_overlap_check
// Stores disk extents and reports every stored extent of another owner that
// overlaps each new one, followed by a closing result with the hit total since reset.
// ----------------------------------------------------------------------------
// One extent is taken at a time. A nonzero extent that finds room in the
// table is taken, compared with each stored entry in turn through the single
// compare unit, one entry per cycle while no pair result is held (the table
// gives one registered read a cycle), and then given its closing result. A
// zero-length extent, or one that meets a full table, goes straight to its
// closing result. Each pair result that finds the output register still
// occupied holds the scan until it is taken. in_tready is high only between
// extents. The table needs no clearing after reset.
module cross_owner_extent_overlap_check #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input extent channel
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // start_address, length, fragment, owner_high, owner_low
  input  logic [coeoc_pkg::IN_DATA_W-1:0]      in_tdata,
  // result channel
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // other_start, other_length, other_fragment, other_owner_high,
  // other_owner_low, hit_total
  output logic [coeoc_pkg::OUT_DATA_W-1:0]     out_tdata,
  // status
  output logic [coeoc_pkg::STAT_W-1:0]         out_tuser,
  output logic                                 out_tlast
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMP   = 2'd1;
  localparam logic [1:0] ST_CLOSE = 2'd2;

  logic [1:0]                        state_r, state_nxt;
  logic [CW-1:0]                     cnt_r, cnt_nxt;
  logic [coeoc_pkg::HITS_W-1:0]      hits_r, hits_nxt, hits_inc;
  logic [AW-1:0]                     idx_r, idx_nxt, last_idx, rd_addr;
  coeoc_pkg::status_t                cls_status_r, cls_status_nxt;
  coeoc_pkg::entry_t                 cur_r, in_entry, rd_data_r;
  logic [coeoc_pkg::ADDR_W:0]        cur_end_r;
  logic [coeoc_pkg::ADDR_W:0]        other_end;

  coeoc_pkg::entry_t                 tbl_mem [TABLE_DEPTH];

  logic                              out_valid_r, out_valid_nxt;
  coeoc_pkg::entry_t                 out_entry_r;
  logic [coeoc_pkg::HITS_W-1:0]      out_hits_r;
  coeoc_pkg::status_t                out_status_r;
  logic                              out_last_r;

  logic in_xfer, out_free, same_owner, hit, advance;
  logic load_pair, load_close, wr_en;

  assign in_entry  = coeoc_pkg::entry_t'(in_tdata);
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign last_idx  = AW'(cnt_r - CW'(1));

  // compare unit: owner check and 65-bit interval overlap
  assign other_end  = {1'b0, rd_data_r.start} + {1'b0, rd_data_r.length};
  assign same_owner = (rd_data_r.owner_high == cur_r.owner_high) &&
                      (rd_data_r.owner_low == cur_r.owner_low);
  assign hit        = !same_owner && (rd_data_r.length != '0) &&
                      ({1'b0, rd_data_r.start} < cur_end_r) &&
                      ({1'b0, cur_r.start} < other_end);

  assign hits_inc   = (hits_r == '1) ? hits_r : hits_r + 1'b1;
  assign load_pair  = (state_r == ST_CMP) && hit && out_free;
  assign advance    = (state_r == ST_CMP) && (!hit || out_free);
  assign load_close = (state_r == ST_CLOSE) && out_free;
  assign wr_en      = load_close && (cls_status_r == coeoc_pkg::STATUS_DONE);

  // read address: entry 0 while idle, next entry once this one is settled
  always_comb begin
    if (state_r == ST_IDLE) begin
      rd_addr = '0;
    end else if (advance) begin
      rd_addr = idx_r + 1'b1;
    end else begin
      rd_addr = idx_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    cls_status_nxt = cls_status_r;
    cnt_nxt        = cnt_r;
    hits_nxt       = hits_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          idx_nxt = '0;
          if (in_entry.length == '0) begin
            cls_status_nxt = coeoc_pkg::STATUS_ZERO;
            state_nxt      = ST_CLOSE;
          end else if (cnt_r >= CW'(TABLE_DEPTH)) begin
            cls_status_nxt = coeoc_pkg::STATUS_FULL;
            state_nxt      = ST_CLOSE;
          end else begin
            cls_status_nxt = coeoc_pkg::STATUS_DONE;
            state_nxt      = (cnt_r == '0) ? ST_CLOSE : ST_CMP;
          end
        end
      end
      ST_CMP: begin
        if (load_pair) begin
          hits_nxt = hits_inc;
        end
        if (advance) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r == last_idx) begin
            state_nxt = ST_CLOSE;
          end
        end
      end
      ST_CLOSE: begin
        if (load_close) begin
          state_nxt = ST_IDLE;
          if (wr_en) begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      hits_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      hits_r      <= hits_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output register handshake
  always_comb begin
    if (load_pair || load_close) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // current extent and scan position
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    cls_status_r <= cls_status_nxt;
    if (in_xfer) begin
      cur_r     <= in_entry;
      cur_end_r <= {1'b0, in_entry.start} + {1'b0, in_entry.length};
    end
  end

  // extent table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[cnt_r[AW-1:0]] <= cur_r;
    end
    rd_data_r <= tbl_mem[rd_addr];
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load_pair) begin
      out_entry_r  <= rd_data_r;
      out_hits_r   <= hits_inc;
      out_status_r <= coeoc_pkg::STATUS_PAIR;
      out_last_r   <= 1'b0;
    end else if (load_close) begin
      out_entry_r  <= '0;
      out_hits_r   <= hits_r;
      out_status_r <= cls_status_r;
      out_last_r   <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_hits_r, out_entry_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP |-> (cnt_r != '0) && ({1'b0, idx_r} < cnt_r))
    else $error("scan index outside stored entries");

  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("stored extent not counted");

  a_hits_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 hits_r >= $past(hits_r))
    else $error("hit total went down");

  a_last_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser != coeoc_pkg::STATUS_PAIR)))
    else $error("tlast does not match result status");

endmodule
